/* design/slip_pkg.sv */
// Shared types, constants and helpers for the SLIP frame codec.
`timescale 1ns / 1ps
package slip_pkg;
	localparam int QUEUE_DEPTH = 2;
	localparam int CFG_AW      = 3;
	localparam int CFG_DW      = 8;
	localparam int MAX_RES     = 4;

	typedef logic [7:0] byte_t;
	typedef logic [1:0] slot_idx_t;

	typedef enum logic [1:0] {
		KIND_DATA = 2'd0,
		KIND_END  = 2'd1,
		KIND_ERR  = 2'd2
	} kind_t;

	localparam logic [CFG_AW-1:0] REG_DIRECTION    = 3'd0;
	localparam logic [CFG_AW-1:0] REG_BOUNDARY     = 3'd1;
	localparam logic [CFG_AW-1:0] REG_ESCAPE       = 3'd2;
	localparam logic [CFG_AW-1:0] REG_BOUNDARY_SUB = 3'd3;
	localparam logic [CFG_AW-1:0] REG_ESCAPE_SUB   = 3'd4;

	localparam logic  DIR_ENCODE = 1'b0;
	localparam logic  DIR_DECODE = 1'b1;

	localparam byte_t RST_BOUNDARY     = 8'd192;
	localparam byte_t RST_ESCAPE       = 8'd219;
	localparam byte_t RST_BOUNDARY_SUB = 8'd220;
	localparam byte_t RST_ESCAPE_SUB   = 8'd221;

	typedef struct packed {
		byte_t data;
		kind_t kind;
	} res_t;

	// One accepted item's worth of results, slot 0 sent first.
	typedef struct packed {
		slot_idx_t                 last_idx;
		res_t [MAX_RES-1:0]        slot;
	} desc_t;

	// Front to queue.
	typedef struct packed {
		logic  push;
		desc_t desc;
	} push_t;

	// Queue to back.
	typedef struct packed {
		logic  valid;
		desc_t desc;
	} head_t;

	function automatic res_t mk_res(input byte_t d, input kind_t k);
		res_t r;
		r.data = d;
		r.kind = k;
		return r;
	endfunction
endpackage

/* design/slip_front.sv */
// Front end: config registers, framing state and classification of each input item.
`timescale 1ns / 1ps
module slip_front import slip_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [CFG_AW-1:0] cfg_addr,
	input  logic [CFG_DW-1:0] cfg_data,
	input  logic              s_axis_tvalid,
	output logic              s_axis_tready,
	input  byte_t             s_axis_tdata,
	input  logic              s_axis_tlast,
	input  logic              q_full,
	output push_t             push_o
);
	logic  dir_q;
	byte_t bnd_q, esc_q, bsub_q, esub_q;
	logic  in_frame_q, esc_pend_q, disc_q;
	logic  in_frame_nxt, esc_pend_nxt, disc_nxt;
	logic  has_res;
	desc_t desc;
	logic  accept;
	logic  dir_clear;

	assign s_axis_tready = !q_full;
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign dir_clear     = cfg_we && (cfg_addr == REG_DIRECTION) && (cfg_data[0] != dir_q);

	always_comb begin
		logic [2:0] n;
		n            = 3'd0;
		desc         = '0;
		has_res      = 1'b0;
		in_frame_nxt = in_frame_q;
		esc_pend_nxt = esc_pend_q;
		disc_nxt     = disc_q;
		if (dir_q == DIR_ENCODE) begin
			if (!in_frame_q) begin
				desc.slot[n[1:0]] = mk_res(bnd_q, KIND_DATA);
				n = n + 3'd1;
			end
			if (s_axis_tdata == bnd_q) begin
				desc.slot[n[1:0]] = mk_res(esc_q, KIND_DATA);
				n = n + 3'd1;
				desc.slot[n[1:0]] = mk_res(bsub_q, KIND_DATA);
				n = n + 3'd1;
			end else if (s_axis_tdata == esc_q) begin
				desc.slot[n[1:0]] = mk_res(esc_q, KIND_DATA);
				n = n + 3'd1;
				desc.slot[n[1:0]] = mk_res(esub_q, KIND_DATA);
				n = n + 3'd1;
			end else begin
				desc.slot[n[1:0]] = mk_res(s_axis_tdata, KIND_DATA);
				n = n + 3'd1;
			end
			if (s_axis_tlast) begin
				desc.slot[n[1:0]] = mk_res(bnd_q, KIND_DATA);
				n = n + 3'd1;
			end
			in_frame_nxt  = !s_axis_tlast;
			has_res       = 1'b1;
			desc.last_idx = slot_idx_t'(n - 3'd1);
		end else begin
			desc.last_idx = '0;
			if (disc_q) begin
				if (s_axis_tdata == bnd_q) begin
					disc_nxt     = 1'b0;
					esc_pend_nxt = 1'b0;
					in_frame_nxt = !in_frame_q;
				end
			end else if (esc_pend_q) begin
				esc_pend_nxt = 1'b0;
				has_res      = 1'b1;
				if (s_axis_tdata == bnd_q) begin
					in_frame_nxt = 1'b0;
					desc.slot[0] = mk_res('0, KIND_ERR);
				end else if (s_axis_tdata == esub_q) begin
					desc.slot[0] = mk_res(esc_q, KIND_DATA);
				end else if (s_axis_tdata == bsub_q) begin
					desc.slot[0] = mk_res(bnd_q, KIND_DATA);
				end else begin
					disc_nxt     = 1'b1;
					in_frame_nxt = 1'b1;
					desc.slot[0] = mk_res('0, KIND_ERR);
				end
			end else if (s_axis_tdata == bnd_q) begin
				if (in_frame_q) begin
					in_frame_nxt = 1'b0;
					has_res      = 1'b1;
					desc.slot[0] = mk_res('0, KIND_END);
				end else begin
					in_frame_nxt = 1'b1;
				end
			end else if (!in_frame_q) begin
				disc_nxt     = 1'b1;
				has_res      = 1'b1;
				desc.slot[0] = mk_res('0, KIND_ERR);
			end else if (s_axis_tdata == esc_q) begin
				esc_pend_nxt = 1'b1;
			end else begin
				has_res      = 1'b1;
				desc.slot[0] = mk_res(s_axis_tdata, KIND_DATA);
			end
		end
	end

	assign push_o.push = accept && has_res;
	assign push_o.desc = desc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dir_q  <= DIR_ENCODE;
			bnd_q  <= RST_BOUNDARY;
			esc_q  <= RST_ESCAPE;
			bsub_q <= RST_BOUNDARY_SUB;
			esub_q <= RST_ESCAPE_SUB;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_DIRECTION:    dir_q  <= cfg_data[0];
				REG_BOUNDARY:     bnd_q  <= cfg_data;
				REG_ESCAPE:       esc_q  <= cfg_data;
				REG_BOUNDARY_SUB: bsub_q <= cfg_data;
				REG_ESCAPE_SUB:   esub_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q <= 1'b0;
			esc_pend_q <= 1'b0;
			disc_q     <= 1'b0;
		end else if (dir_clear) begin
			in_frame_q <= 1'b0;
			esc_pend_q <= 1'b0;
			disc_q     <= 1'b0;
		end else if (accept) begin
			in_frame_q <= in_frame_nxt;
			esc_pend_q <= esc_pend_nxt;
			disc_q     <= disc_nxt;
		end
	end
endmodule

/* design/slip_queue.sv */
// Short queue of result descriptors between front and back end.
`timescale 1ns / 1ps
module slip_queue import slip_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic  clk,
	input  logic  arst_n,
	input  push_t push_i,
	input  logic  pop,
	output logic  full,
	output head_t head_o
);
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	desc_t         entry_q [DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_push, do_pop;

	assign full         = (count_q == CW'(DEPTH));
	assign do_push      = push_i.push && !full;
	assign do_pop       = pop && (count_q != '0);
	assign head_o.valid = (count_q != '0);
	assign head_o.desc  = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_i.desc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end
endmodule

/* design/slip_back.sv */
// Back end: sends queued results one per cycle while tready is high, through an output register.
`timescale 1ns / 1ps
module slip_back import slip_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  head_t head_i,
	output logic  pop,
	output logic  m_axis_tvalid,
	input  logic  m_axis_tready,
	output byte_t m_axis_tdata,
	output kind_t m_axis_tuser,
	output logic  m_axis_tlast
);
	slot_idx_t idx_q;
	logic      vld_q;
	byte_t     data_q;
	kind_t     kind_q;
	logic      last_q;
	logic      load;
	logic      at_last;
	res_t      cur;

	assign load    = head_i.valid && (!vld_q || m_axis_tready);
	assign cur     = head_i.desc.slot[idx_q];
	assign at_last = (idx_q == head_i.desc.last_idx);
	assign pop     = load && at_last;

	assign m_axis_tvalid = vld_q;
	assign m_axis_tdata  = data_q;
	assign m_axis_tuser  = kind_q;
	assign m_axis_tlast  = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
			idx_q <= '0;
		end else begin
			if (load) begin
				vld_q <= 1'b1;
				idx_q <= at_last ? '0 : idx_q + 1'b1;
			end else if (m_axis_tready) begin
				vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= cur.data;
			kind_q <= cur.kind;
			last_q <= at_last;
		end
	end
endmodule

/* design/slip_frame_codec.sv */
// Top level of the SLIP frame codec: front end, descriptor queue and back end.
`timescale 1ns / 1ps
// Byte-stream SLIP framer; direction register selects encode (0) or decode (1).
// An input item is taken every cycle while the descriptor queue has room. Each
// item yields zero to four result bytes, which leave one per cycle from the
// output register while the receiver is ready, once queued.
// Sustained rate is one item per cycle when each item makes at most one result
// and the receiver keeps up; an encode item that adds a delimiter or escape
// pair holds the output for each of its result bytes, and the input stalls
// once the queue (QDEPTH descriptors) fills. Config writes are expected only
// while idle; a write that changes direction resets the framing state.
module slip_frame_codec import slip_pkg::*; #(
	parameter int QDEPTH = QUEUE_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [CFG_AW-1:0] cfg_addr,
	input  logic [CFG_DW-1:0] cfg_data,
	input  logic              s_axis_tvalid,
	output logic              s_axis_tready,
	input  logic [7:0]        s_axis_tdata,   // data_in
	input  logic              s_axis_tlast,   // end_of_payload
	output logic              m_axis_tvalid,
	input  logic              m_axis_tready,
	output logic [7:0]        m_axis_tdata,   // data_out
	output logic [1:0]        m_axis_tuser,   // kind
	output logic              m_axis_tlast    // last_result
);
	push_t push;
	head_t head;
	logic  q_full;
	logic  pop;
	kind_t kind;

	slip_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_addr      (cfg_addr),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.q_full        (q_full),
		.push_o        (push)
	);

	slip_queue #(.DEPTH(QDEPTH)) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push_i (push),
		.pop    (pop),
		.full   (q_full),
		.head_o (head)
	);

	slip_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head_i        (head),
		.pop           (pop),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (kind),
		.m_axis_tlast  (m_axis_tlast)
	);

	assign m_axis_tuser = kind;
endmodule

/* bench/slip_frame_codec_test.sv */
// Self-checking testbench for the SLIP frame codec: directed and random frames in both directions.
`timescale 1ns / 1ps
module slip_frame_codec_test;
	import slip_pkg::*;

	localparam int HOLD_CYCLES  = 300;
	localparam int DRAIN_CYCLES = 8;
	localparam int STALL_LIMIT  = 4000;

	localparam logic [CFG_AW-1:0] REG_UNUSED_LO = 3'd5;
	localparam logic [CFG_AW-1:0] REG_UNUSED_HI = 3'd7;

	typedef struct {
		byte_t data;
		kind_t kind;
		logic  last;
	} codec_out_t;

	logic              clk;
	logic              arst_n = 1'b0;
	logic              cfg_we = 1'b0;
	logic [CFG_AW-1:0] cfg_addr = '0;
	logic [CFG_DW-1:0] cfg_data = '0;
	logic              s_axis_tvalid = 1'b0;
	logic              s_axis_tready;
	logic [7:0]        s_axis_tdata = '0;   // data_in
	logic              s_axis_tlast = 1'b0; // end_of_payload
	logic              m_axis_tvalid;
	logic              m_axis_tready = 1'b0;
	logic [7:0]        m_axis_tdata;        // data_out
	logic [1:0]        m_axis_tuser;        // kind
	logic              m_axis_tlast;        // last_result

	// predictor copy of registers and framing state
	logic  dir_r;
	byte_t bnd_r, esc_r, bsub_r, esub_r;
	logic  in_frame_r, esc_pend_r, discard_r;

	codec_out_t pending_results[$];
	int         errors = 0;
	int         items_sent = 0;
	logic       tx_gaps_on = 1'b1;
	logic       rx_stalls_on = 1'b0;
	int         hold_seq = 0;
	int         hold_seen = 0;
	int         rx_wait = 0;
	int         idle_cycles = 0;

	slip_frame_codec uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_addr      (cfg_addr),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic byte_t pick_payload();
		case ($urandom_range(0, 9))
			0: return bnd_r;
			1: return esc_r;
			2: return bsub_r;
			3: return esub_r;
			default: return byte_t'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic void clear_framing();
		in_frame_r = 1'b0;
		esc_pend_r = 1'b0;
		discard_r  = 1'b0;
	endfunction

	function automatic void reset_registers();
		dir_r  = DIR_ENCODE;
		bnd_r  = RST_BOUNDARY;
		esc_r  = RST_ESCAPE;
		bsub_r = RST_BOUNDARY_SUB;
		esub_r = RST_ESCAPE_SUB;
		clear_framing();
	endfunction

	function automatic void predict_codec(byte_t b, logic eop);
		codec_out_t step_q[$];
		codec_out_t oi;
		if (dir_r == DIR_ENCODE) begin
			if (!in_frame_r) begin
				step_q.insert(step_q.size(), '{bnd_r, KIND_DATA, 1'b0});
				in_frame_r = 1'b1;
			end
			if (b == bnd_r) begin
				step_q.insert(step_q.size(), '{esc_r, KIND_DATA, 1'b0});
				step_q.insert(step_q.size(), '{bsub_r, KIND_DATA, 1'b0});
			end else if (b == esc_r) begin
				step_q.insert(step_q.size(), '{esc_r, KIND_DATA, 1'b0});
				step_q.insert(step_q.size(), '{esub_r, KIND_DATA, 1'b0});
			end else begin
				step_q.insert(step_q.size(), '{b, KIND_DATA, 1'b0});
			end
			if (eop) begin
				step_q.insert(step_q.size(), '{bnd_r, KIND_DATA, 1'b0});
				in_frame_r = 1'b0;
			end
		end else if (discard_r) begin
			if (b == bnd_r) begin
				discard_r  = 1'b0;
				esc_pend_r = 1'b0;
				in_frame_r = !in_frame_r;
			end
		end else if (esc_pend_r) begin
			esc_pend_r = 1'b0;
			if (b == bnd_r) begin
				in_frame_r = 1'b0;
				step_q.insert(step_q.size(), '{8'h00, KIND_ERR, 1'b0});
			end else if (b == esub_r) begin
				step_q.insert(step_q.size(), '{esc_r, KIND_DATA, 1'b0});
			end else if (b == bsub_r) begin
				step_q.insert(step_q.size(), '{bnd_r, KIND_DATA, 1'b0});
			end else begin
				discard_r  = 1'b1;
				in_frame_r = 1'b1;
				step_q.insert(step_q.size(), '{8'h00, KIND_ERR, 1'b0});
			end
		end else if (b == bnd_r) begin
			if (in_frame_r) begin
				in_frame_r = 1'b0;
				step_q.insert(step_q.size(), '{8'h00, KIND_END, 1'b0});
			end else begin
				in_frame_r = 1'b1;
			end
		end else if (!in_frame_r) begin
			discard_r = 1'b1;
			step_q.insert(step_q.size(), '{8'h00, KIND_ERR, 1'b0});
		end else if (b == esc_r) begin
			esc_pend_r = 1'b1;
		end else begin
			step_q.insert(step_q.size(), '{b, KIND_DATA, 1'b0});
		end
		foreach (step_q[i]) begin
			oi = step_q[i];
			oi.last = (i == step_q.size() - 1);
			pending_results.insert(pending_results.size(), oi);
		end
	endfunction

	task automatic send_item(input byte_t b, input logic eop);
		int gap;
		gap = tx_gaps_on ? pick_gap() : 0;
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= b;
		s_axis_tlast  <= eop;
		do
			@(posedge clk);
		while (!s_axis_tready);
		predict_codec(b, eop);
		items_sent++;
	endtask

	// sender goes quiet until every result is out and the pipe has settled
	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_AW-1:0] idx, input logic [CFG_DW-1:0] val);
		cfg_we   <= 1'b1;
		cfg_addr <= idx;
		cfg_data <= val;
		@(posedge clk);
		case (idx)
			REG_DIRECTION: begin
				if (val[0] != dir_r)
					clear_framing();
				dir_r = val[0];
			end
			REG_BOUNDARY:     bnd_r  = val;
			REG_ESCAPE:       esc_r  = val;
			REG_BOUNDARY_SUB: bsub_r = val;
			REG_ESCAPE_SUB:   esub_r = val;
			default: ;
		endcase
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic write_codes(input byte_t b, input byte_t e, input byte_t bs, input byte_t es);
		write_reg(REG_BOUNDARY, b);
		write_reg(REG_ESCAPE, e);
		write_reg(REG_BOUNDARY_SUB, bs);
		write_reg(REG_ESCAPE_SUB, es);
	endtask

	task automatic send_wire_bytes(input byte_t seq[$]);
		foreach (seq[i])
			send_item(seq[i], 1'($urandom_range(0, 1)));
	endtask

	task automatic test_encode_directed();
		tx_gaps_on   <= 1'b1;
		rx_stalls_on <= 1'b1;
		send_item(8'h00, 1'b0);
		send_item(8'hFF, 1'b0);
		send_item(RST_BOUNDARY, 1'b0);
		send_item(RST_ESCAPE, 1'b0);
		send_item(RST_ESCAPE_SUB, 1'b1);
		send_item(RST_BOUNDARY, 1'b1);
		wait_drained();
	endtask

	task automatic test_decode_directed();
		write_reg(REG_DIRECTION, {7'b0, DIR_DECODE});
		send_wire_bytes('{8'hC0, 8'hFF, 8'hDB, 8'hDC, 8'hDB, 8'hDD, 8'hC0});
		// empty frame
		send_wire_bytes('{8'hC0, 8'hC0});
		// stray byte outside a frame, then the boundary ending the skip opens one
		send_wire_bytes('{8'h55, 8'hC0, 8'h00, 8'hC0});
		// bad escape discards the rest of the frame
		send_wire_bytes('{8'hC0, 8'hDB, 8'h33, 8'h44, 8'hC0});
		// boundary right after escape
		send_wire_bytes('{8'hC0, 8'hDB, 8'hC0});
		wait_drained();
	endtask

	task automatic test_register_corners();
		write_reg(REG_UNUSED_LO, 8'hFF);
		write_reg(REG_UNUSED_HI, 8'h00);
		// boundary and escape share a value while encoding
		write_reg(REG_DIRECTION, {7'b0, DIR_ENCODE});
		write_reg(REG_ESCAPE, RST_BOUNDARY);
		send_item(RST_BOUNDARY, 1'b1);
		wait_drained();
		// equal substitutes while decoding
		write_codes(RST_BOUNDARY, RST_ESCAPE, RST_BOUNDARY_SUB, RST_BOUNDARY_SUB);
		write_reg(REG_DIRECTION, {7'b0, DIR_DECODE});
		send_wire_bytes('{8'hC0, 8'hDB, 8'hDC, 8'hC0});
		wait_drained();
		// extreme code values
		write_codes(8'h00, 8'hFF, 8'h01, 8'hFE);
		send_wire_bytes('{8'h00, 8'hFF, 8'h01, 8'hFF, 8'hFE, 8'h80, 8'h00});
		wait_drained();
	endtask

	task automatic test_encode_random();
		write_reg(REG_DIRECTION, {7'b0, DIR_ENCODE});
		write_codes(8'hFF, 8'h00, 8'h7F, 8'h80);
		for (int i = 0; i < 30; i++) begin
			if (i == 15) begin
				tx_gaps_on   <= 1'b0;
				rx_stalls_on <= 1'b0;
			end
			send_item(pick_payload(), $urandom_range(0, 4) == 0);
		end
		tx_gaps_on   <= 1'b1;
		rx_stalls_on <= 1'b1;
		wait_drained();
	endtask

	task automatic test_backpressure();
		write_codes(RST_BOUNDARY, RST_ESCAPE, RST_BOUNDARY_SUB, RST_ESCAPE_SUB);
		tx_gaps_on <= 1'b0;
		hold_seq   <= hold_seq + 1;
		for (int i = 0; i < 20; i++)
			send_item(($urandom_range(0, 1) != 0) ? bnd_r : esc_r, $urandom_range(0, 2) == 0);
		tx_gaps_on <= 1'b1;
		wait_drained();
	endtask

	task automatic send_decode_burst();
		byte_t seq[$];
		byte_t b;
		int    r;
		r = $urandom_range(0, 99);
		if (r < 70) begin
			seq.insert(seq.size(), bnd_r);
			repeat ($urandom_range(1, 6)) begin
				b = pick_payload();
				if (b == bnd_r) begin
					seq.insert(seq.size(), esc_r);
					seq.insert(seq.size(), bsub_r);
				end else if (b == esc_r) begin
					seq.insert(seq.size(), esc_r);
					seq.insert(seq.size(), esub_r);
				end else begin
					seq.insert(seq.size(), b);
				end
			end
			seq.insert(seq.size(), bnd_r);
		end else if (r < 85) begin
			seq.insert(seq.size(), bnd_r);
			seq.insert(seq.size(), byte_t'($urandom_range(0, 255)));
			seq.insert(seq.size(), esc_r);
			seq.insert(seq.size(), pick_payload());
			seq.insert(seq.size(), byte_t'($urandom_range(0, 255)));
			seq.insert(seq.size(), bnd_r);
		end else begin
			repeat ($urandom_range(1, 3))
				seq.insert(seq.size(), pick_payload());
		end
		send_wire_bytes(seq);
	endtask

	task automatic test_decode_random();
		byte_t b;
		int    stop_at;
		write_reg(REG_DIRECTION, {7'b0, DIR_DECODE});
		stop_at = items_sent + 20;
		while (items_sent < stop_at)
			send_decode_burst();
		wait_drained();
		b = byte_t'($urandom_range(0, 255));
		write_codes(b, b ^ byte_t'($urandom_range(1, 255)), byte_t'($urandom_range(0, 255)),
			byte_t'($urandom_range(0, 255)));
		stop_at = items_sent + 12;
		while (items_sent < stop_at)
			send_decode_burst();
		wait_drained();
	endtask

	// receiver: random stalls, plus a long hold-off when requested
	always @(posedge clk) begin
		if (hold_seq != hold_seen) begin
			hold_seen     <= hold_seq;
			rx_wait       <= HOLD_CYCLES;
			m_axis_tready <= 1'b0;
		end else if (rx_wait > 0) begin
			rx_wait       <= rx_wait - 1;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
			rx_wait       <= rx_stalls_on ? pick_gap() : 0;
		end
	end

	always @(posedge clk) begin
		codec_out_t e;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_results.size() == 0) begin
				errors++;
				$display("%0t: unexpected result data %02h kind %0d last %0b", $time,
					m_axis_tdata, m_axis_tuser, m_axis_tlast);
			end else begin
				e = pending_results.pop_front();
				if (m_axis_tdata !== e.data) begin
					errors++;
					$display("%0t: data_out expected %02h actual %02h", $time, e.data,
						m_axis_tdata);
				end
				if (m_axis_tuser !== e.kind) begin
					errors++;
					$display("%0t: kind expected %0d actual %0d", $time, e.kind, m_axis_tuser);
				end
				if (m_axis_tlast !== e.last) begin
					errors++;
					$display("%0t: last_result expected %0b actual %0b", $time, e.last,
						m_axis_tlast);
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || cfg_we || (s_axis_tvalid && s_axis_tready)
				|| (m_axis_tvalid && m_axis_tready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		reset_registers();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_encode_directed();
		test_decode_directed();
		test_register_corners();
		test_encode_random();
		test_backpressure();
		test_decode_random();
		wait_drained();
		if (errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end
endmodule
